// ----- hdl/brfs_pkg.sv -----
// Shared types and constants for the brute-force radius search block.
package brfs_pkg;

    // Width of the squared radius register.
    localparam int RADIUS_BITS = 33;

    // Reset value of the squared radius.
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 33'd429484;

    // Width of the label field on the result stream.
    localparam int OUT_LABEL_BITS = 16;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [2:0] {
        ST_CLEARED = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL = 3'd2,
        ST_MATCH = 3'd3,
        ST_NOMATCH = 3'd4
    } status_t;

    // Control that goes with each scan step into the distance unit.
    typedef struct packed {
        logic adv;
        logic valid;
        logic fin;
    } scan_ctl_t;

    // Outcome of one scan step leaving the distance unit.
    typedef struct packed {
        logic valid;
        logic hit;
        logic fin;
    } scan_res_t;

endpackage

// ----- hdl/brfs_cell.sv -----
// One storage cell of the point ring: holds a single point and its label.
module brfs_cell #(
    parameter int POINT_BITS = 48
) (
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic                  wr_en,
    input  logic [POINT_BITS-1:0] wr_point,
    input  logic [POINT_BITS-1:0] nb_point,
    output logic [POINT_BITS-1:0] point
);

    logic [POINT_BITS-1:0] point_reg;

    // A write from the insert path wins; otherwise the cell takes its neighbor's point.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_reg <= wr_point;
        end
        else if (shift_en)
        begin
            point_reg <= nb_point;
        end
    end

    assign point = point_reg;

endmodule

// ----- hdl/brfs_dist.sv -----
// Two-stage squared distance unit with the radius compare at its output.
module brfs_dist #(
    parameter int COORD_BITS = 16,
    parameter int LABEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  brfs_pkg::scan_ctl_t                 ctl,
    input  logic [2*COORD_BITS+LABEL_BITS-1:0]  point,
    input  logic [COORD_BITS-1:0]               qx,
    input  logic [COORD_BITS-1:0]               qy,
    input  logic [brfs_pkg::RADIUS_BITS-1:0]    radius,
    output brfs_pkg::scan_res_t                 res,
    output logic [LABEL_BITS-1:0]               label
);

    localparam int SQW = 2 * COORD_BITS;
    localparam int SUMW = SQW + 1;
    localparam int CMPW = (SUMW > brfs_pkg::RADIUS_BITS) ? SUMW : brfs_pkg::RADIUS_BITS;

    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [LABEL_BITS-1:0] plab;
    logic [COORD_BITS-1:0] dx_next;
    logic [COORD_BITS-1:0] dy_next;

    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [LABEL_BITS-1:0] lab1_reg;
    logic                  v1_reg;
    logic                  f1_reg;

    logic [SQW-1:0]        sqx_next;
    logic [SQW-1:0]        sqy_next;
    logic [SQW-1:0]        sqx_reg;
    logic [SQW-1:0]        sqy_reg;
    logic [LABEL_BITS-1:0] lab2_reg;
    logic                  v2_reg;
    logic                  f2_reg;

    logic [SUMW-1:0]       dist_sum;

    // Unpack the point at the head of the ring.
    assign px = point[COORD_BITS-1:0];
    assign py = point[SQW-1:COORD_BITS];
    assign plab = point[SQW+LABEL_BITS-1:SQW];

    // Absolute coordinate differences.
    assign dx_next = (px >= qx) ? (px - qx) : (qx - px);
    assign dy_next = (py >= qy) ? (py - qy) : (qy - py);

    // Squares of the registered differences.
    assign sqx_next = SQW'(dx_reg) * SQW'(dx_reg);
    assign sqy_next = SQW'(dy_reg) * SQW'(dy_reg);

    // Stage control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            f1_reg <= 1'b0;
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            v1_reg <= ctl.valid;
            f1_reg <= ctl.fin;
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            lab1_reg <= plab;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            lab2_reg <= lab1_reg;
        end
    end

    // Sum of squares against the squared radius, strictly less than.
    assign dist_sum = SUMW'(sqx_reg) + SUMW'(sqy_reg);
    assign res.valid = v2_reg;
    assign res.fin = f2_reg;
    assign res.hit = CMPW'(dist_sum) < CMPW'(radius);
    assign label = lab2_reg;

endmodule

// ----- hdl/brute_force_radius_search.sv -----
// Top level of the brute-force fixed-radius near-neighbor search block.
//
// Requests enter on s_axis: tuser is the request kind (clear, insert, query),
// tdata packs coord_x, coord_y and point_label. Results leave on m_axis:
// tuser is the status, tdata the matching label, tlast marks the final result
// of each request. cfg_wr_en with cfg_wr_data loads the squared radius.
// Clear and insert give their single result in the cycle after they are
// taken. A query rotates the ring of CAPACITY point cells once around, one
// point per cycle while the output is not stalled, through a two-stage
// distance unit, and holds the input until its final result is loaded. Matches
// come out in insertion order; one match is held back so that the final one
// can carry tlast, and a query with no match gives one no-match result.
// Reset empties the table and restores the default radius. When the receiver
// stalls, the result waits in the output register and the whole scan pauses
// with it; no request is taken while a result is waiting and not taken.
module brute_force_radius_search #(
    parameter int CAPACITY = 64,
    parameter int COORD_BITS = 16,
    parameter int LABEL_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Bits from low: coord_x, coord_y, point_label, zero fill to whole bytes.
    input  logic [((2*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Bits from low: req_type.
    input  logic [1:0]                             s_axis_tuser,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Bits from low: match_label.
    output logic [15:0]                            m_axis_tdata,
    // Bits from low: status.
    output logic [2:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   cfg_wr_en,
    input  logic [brfs_pkg::RADIUS_BITS-1:0]       cfg_wr_data
);

    localparam int PW = 2 * COORD_BITS + LABEL_BITS;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [PW-1:0]                      ring [CAPACITY];
    logic [PW-1:0]                      in_point;
    logic                               in_acc;
    brfs_pkg::req_t                     in_req;
    logic                               adv;
    logic                               rotate;
    logic                               ins_ok;
    brfs_pkg::scan_ctl_t                ctl;
    brfs_pkg::scan_res_t                res;
    logic [LABEL_BITS-1:0]              res_label;
    logic [31:0]                        pend_wide;

    logic [brfs_pkg::RADIUS_BITS-1:0]   radius_reg;
    logic [CW-1:0]                      fill_reg;
    logic [CW-1:0]                      fill_next;
    logic [CW-1:0]                      scan_reg;
    logic [CW-1:0]                      scan_next;
    logic                               busy_reg;
    logic                               busy_next;
    logic                               issue_reg;
    logic                               issue_next;
    logic [COORD_BITS-1:0]              qx_reg;
    logic [COORD_BITS-1:0]              qy_reg;
    logic                               pend_reg;
    logic                               pend_next;
    logic [LABEL_BITS-1:0]              pend_lab_reg;
    logic [LABEL_BITS-1:0]              pend_lab_next;
    logic                               ov_reg;
    logic                               ov_next;
    brfs_pkg::status_t                  ost_reg;
    brfs_pkg::status_t                  ost_next;
    logic [brfs_pkg::OUT_LABEL_BITS-1:0] olab_reg;
    logic [brfs_pkg::OUT_LABEL_BITS-1:0] olab_next;
    logic                               olast_reg;
    logic                               olast_next;
    logic                               oload;

    // Handshake: the pipeline moves whenever the output slot is free or being emptied.
    assign adv = !ov_reg || m_axis_tready;
    assign s_axis_tready = !busy_reg && adv;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_req = brfs_pkg::req_t'(s_axis_tuser);
    assign in_point = s_axis_tdata[PW-1:0];
    assign ins_ok = in_acc && (in_req == brfs_pkg::REQ_INSERT) && (fill_reg < CW'(CAPACITY));

    // Scan issue: the ring turns once around, then a final flush step follows.
    assign rotate = adv && issue_reg && (scan_reg != CW'(CAPACITY));
    assign ctl.adv = adv;
    assign ctl.valid = issue_reg && (scan_reg < fill_reg);
    assign ctl.fin = issue_reg && (scan_reg == CW'(CAPACITY));

    // Ring of point cells; cell 0 is the head that feeds the distance unit.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        brfs_cell #(
            .POINT_BITS(PW)
        ) u_cell (
            .clk     (clk),
            .shift_en(rotate),
            .wr_en   (ins_ok && (fill_reg == CW'(i))),
            .wr_point(in_point),
            .nb_point(ring[(i + 1) % CAPACITY]),
            .point   (ring[i])
        );
    end

    brfs_dist #(
        .COORD_BITS(COORD_BITS),
        .LABEL_BITS(LABEL_BITS)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .point (ring[0]),
        .qx    (qx_reg),
        .qy    (qy_reg),
        .radius(radius_reg),
        .res   (res),
        .label (res_label)
    );

    assign pend_wide = 32'(pend_lab_reg);

    // Request handling, match hold-back and output register loading.
    always_comb
    begin
        fill_next = fill_reg;
        scan_next = scan_reg;
        busy_next = busy_reg;
        issue_next = issue_reg;
        pend_next = pend_reg;
        pend_lab_next = pend_lab_reg;
        oload = 1'b0;
        ost_next = ost_reg;
        olab_next = olab_reg;
        olast_next = olast_reg;

        if (in_acc)
        begin
            case (in_req)
                brfs_pkg::REQ_CLEAR:
                begin
                    fill_next = '0;
                    oload = 1'b1;
                    ost_next = brfs_pkg::ST_CLEARED;
                    olab_next = '0;
                    olast_next = 1'b1;
                end
                brfs_pkg::REQ_INSERT:
                begin
                    oload = 1'b1;
                    olab_next = '0;
                    olast_next = 1'b1;
                    if (ins_ok)
                    begin
                        fill_next = fill_reg + 1'b1;
                        ost_next = brfs_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        ost_next = brfs_pkg::ST_FULL;
                    end
                end
                brfs_pkg::REQ_QUERY:
                begin
                    busy_next = 1'b1;
                    issue_next = 1'b1;
                    scan_next = '0;
                    pend_next = 1'b0;
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end

        // Step counter of the ring rotation.
        if (adv && issue_reg)
        begin
            if (scan_reg == CW'(CAPACITY))
            begin
                issue_next = 1'b0;
            end
            else
            begin
                scan_next = scan_reg + 1'b1;
            end
        end

        // A new match releases the one held back; the flush step ends the run.
        if (adv && res.valid && res.hit)
        begin
            if (pend_reg)
            begin
                oload = 1'b1;
                ost_next = brfs_pkg::ST_MATCH;
                olab_next = pend_wide[brfs_pkg::OUT_LABEL_BITS-1:0];
                olast_next = 1'b0;
            end
            pend_next = 1'b1;
            pend_lab_next = res_label;
        end
        else if (adv && res.fin)
        begin
            oload = 1'b1;
            olast_next = 1'b1;
            busy_next = 1'b0;
            pend_next = 1'b0;
            if (pend_reg)
            begin
                ost_next = brfs_pkg::ST_MATCH;
                olab_next = pend_wide[brfs_pkg::OUT_LABEL_BITS-1:0];
            end
            else
            begin
                ost_next = brfs_pkg::ST_NOMATCH;
                olab_next = '0;
            end
        end

        if (oload)
        begin
            ov_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= brfs_pkg::RADIUS_RESET;
            fill_reg <= '0;
            scan_reg <= '0;
            busy_reg <= 1'b0;
            issue_reg <= 1'b0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            fill_reg <= fill_next;
            scan_reg <= scan_next;
            busy_reg <= busy_next;
            issue_reg <= issue_next;
            pend_reg <= pend_next;
            ov_reg <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc && (in_req == brfs_pkg::REQ_QUERY))
        begin
            qx_reg <= in_point[COORD_BITS-1:0];
            qy_reg <= in_point[2*COORD_BITS-1:COORD_BITS];
        end
        pend_lab_reg <= pend_lab_next;
        ost_reg <= ost_next;
        olab_reg <= olab_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser = ost_reg;
    assign m_axis_tdata = olab_reg;
    assign m_axis_tlast = olast_reg;

endmodule

// ----- hdl/brfs_checker.sv -----
// Port-level checks for the radius search block, bound to its top level.
module brfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic [1:0]  s_axis_tuser,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // No request is taken while a result waits on a stalled receiver.
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while output is stalled");

    // Clear and insert give their result in the next cycle.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tuser == brfs_pkg::REQ_CLEAR || s_axis_tuser == brfs_pkg::REQ_INSERT)
        |=> m_axis_tvalid && m_axis_tlast)
        else $error("missing result for clear or insert");

    // Every result that is not a match ends its run and carries no label.
    a_nonmatch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != brfs_pkg::ST_MATCH)
        |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("non-match result without last or with a label");

endmodule

bind brute_force_radius_search brfs_checker u_brfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
);

// ----- sim/brfs_checker.sv -----
// Checker that predicts the radius search results and compares them with the block's output.
module brfs_scoreboard #(
    parameter int CAPACITY = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Bits from low: coord_x, coord_y, point_label.
    input  logic [47:0]                      s_axis_tdata,
    // Bits from low: req_type.
    input  logic [1:0]                       s_axis_tuser,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // Bits from low: match_label.
    input  logic [15:0]                      m_axis_tdata,
    // Bits from low: status.
    input  logic [2:0]                       m_axis_tuser,
    input  logic                             m_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [brfs_pkg::RADIUS_BITS-1:0] cfg_wr_data,
    output int                               failures,
    output int                               outstanding
);

    typedef struct packed {
        brfs_pkg::status_t status;
        logic [15:0]       tag;
        logic              fin;
    } search_result_t;

    // Shadow copy of the point table and the squared radius.
    logic [15:0]                      point_x [CAPACITY];
    logic [15:0]                      point_y [CAPACITY];
    logic [15:0]                      point_tag [CAPACITY];
    int unsigned                      point_count;
    logic [brfs_pkg::RADIUS_BITS-1:0] radius_sq;

    search_result_t expected_results [$];
    int             error_count = 0;

    assign failures = error_count;

    // Square of the distance along one axis, exact in 32 bits.
    function automatic logic [31:0] axis_sq(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = (a >= b) ? a - b : b - a;
        return 32'(d) * 32'(d);
    endfunction

    // Appends one result to the end of the list of those due.
    function automatic void expect_result(input brfs_pkg::status_t st, input logic [15:0] tag,
                                          input logic fin);
        search_result_t r;
        r.status = st;
        r.tag = tag;
        r.fin = fin;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Updates the shadow table for one request and queues the results it should give.
    function automatic void search_table(input brfs_pkg::req_t kind, input logic [15:0] qx,
                                         input logic [15:0] qy, input logic [15:0] tag);
        logic [32:0]    sq_dist;
        search_result_t final_hit;
        int             hits;
        hits = 0;
        case (kind)
            brfs_pkg::REQ_CLEAR:
            begin
                point_count = 0;
                expect_result(brfs_pkg::ST_CLEARED, 16'd0, 1'b1);
            end
            brfs_pkg::REQ_INSERT:
            begin
                if (point_count >= CAPACITY)
                    expect_result(brfs_pkg::ST_FULL, 16'd0, 1'b1);
                else
                begin
                    point_x[point_count] = qx;
                    point_y[point_count] = qy;
                    point_tag[point_count] = tag;
                    point_count++;
                    expect_result(brfs_pkg::ST_INSERTED, 16'd0, 1'b1);
                end
            end
            brfs_pkg::REQ_QUERY:
            begin
                // Oldest point first; only points within the strict radius match.
                for (int i = 0; i < point_count; i++)
                begin
                    sq_dist = {1'b0, axis_sq(point_x[i], qx)} + {1'b0, axis_sq(point_y[i], qy)};
                    if (sq_dist < radius_sq)
                    begin
                        expect_result(brfs_pkg::ST_MATCH, point_tag[i], 1'b0);
                        hits++;
                    end
                end
                if (hits == 0)
                    expect_result(brfs_pkg::ST_NOMATCH, 16'd0, 1'b1);
                else
                begin
                    final_hit = expected_results.pop_back();
                    expect_result(final_hit.status, final_hit.tag, 1'b1);
                end
            end
            default:
                ;
        endcase
    endfunction

    // Follow both streams and the register port; compare each result with the oldest one due.
    always @(posedge clk or negedge rst_n)
    begin : watch
        search_result_t want;
        if (!rst_n)
        begin
            point_count = 0;
            radius_sq = brfs_pkg::RADIUS_RESET;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                radius_sq = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                search_table(brfs_pkg::req_t'(s_axis_tuser), s_axis_tdata[15:0],
                             s_axis_tdata[31:16], s_axis_tdata[47:32]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with none due: status %0d, label %h, last %b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status !== brfs_pkg::status_t'(m_axis_tuser))
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        error_count++;
                    end
                    if (want.tag !== m_axis_tdata)
                    begin
                        $error("match_label: expected %h, got %h", want.tag, m_axis_tdata);
                        error_count++;
                    end
                    if (want.fin !== m_axis_tlast)
                    begin
                        $error("last: expected %b, got %b", want.fin, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- sim/brute_force_radius_search_tb.sv -----
// Testbench top for the radius search block: stimulus, stream idling and the verdict.
module brute_force_radius_search_tb;

    localparam int CAPACITY = 64;
    localparam logic [brfs_pkg::RADIUS_BITS-1:0] RADIUS_MAX = 33'd8589672451;
    localparam int TARGET_ITEMS = 310;
    localparam int QUIET_ITEMS = 40;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic [47:0]                      s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [15:0]                      m_axis_tdata;
    logic [2:0]                       m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [brfs_pkg::RADIUS_BITS-1:0] cfg_wr_data = '0;

    int failures;
    int outstanding;

    // Idling controls for the sender and the receiver.
    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;
    bit quiet = 1'b0;
    bit long_hold_pending = 1'b0;
    bit hold_done = 1'b0;

    // Run statistics for the summary.
    int clear_count = 0;
    int insert_count = 0;
    int query_count = 0;
    int unused_count = 0;
    int radius_loads = 0;
    int match_count = 0;
    int nomatch_count = 0;
    int dropped_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    brute_force_radius_search #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (16),
        .LABEL_BITS (16)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    brfs_scoreboard #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_pending = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && out_idle_on && $urandom_range(0, 6) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("No request or result moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Tally result kinds for the summary.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            case (brfs_pkg::status_t'(m_axis_tuser))
                brfs_pkg::ST_MATCH:   match_count++;
                brfs_pkg::ST_NOMATCH: nomatch_count++;
                brfs_pkg::ST_FULL:    dropped_count++;
                default:              ;
            endcase
        end
    end

    // Offer one request and hold it until the block takes it, then maybe idle.
    task automatic send_request(input brfs_pkg::req_t kind, input logic [15:0] x,
                                input logic [15:0] y, input logic [15:0] tag);
        s_axis_tuser <= kind;
        s_axis_tdata <= {tag, y, x};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (kind)
            brfs_pkg::REQ_CLEAR:  clear_count++;
            brfs_pkg::REQ_INSERT: insert_count++;
            brfs_pkg::REQ_QUERY:  query_count++;
            default:              unused_count++;
        endcase
        if (!quiet && in_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Stop sending, wait for every due result, then let the SETTLE_CYCLES settle time pass.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_radius(input logic [brfs_pkg::RADIUS_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        radius_loads++;
    endtask

    // A coordinate scattered around a center, clamped to the 16-bit coordinate range.
    function automatic logic [15:0] near_coord(input logic [15:0] center,
                                               input int unsigned spread);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Radius for each random phase, cycling through the largest, tiny, zero, typical and random values.
    function automatic logic [brfs_pkg::RADIUS_BITS-1:0] pick_radius(input int phase);
        logic [brfs_pkg::RADIUS_BITS-1:0] v;
        case (phase % 5)
            0: v = RADIUS_MAX;
            1: v = brfs_pkg::RADIUS_BITS'($urandom_range(1, 4000));
            2: v = '0;
            3: v = brfs_pkg::RADIUS_BITS'($urandom_range(100000, 50000000));
            default:
            begin
                v = {1'($urandom_range(0, 1)), 32'($urandom)};
                if (v > RADIUS_MAX)
                    v = RADIUS_MAX;
            end
        endcase
        return v;
    endfunction

    // Clear, fill with a cluster of points, then query around the cluster.
    task automatic run_sequence(input bit fill_up);
        logic [15:0] cx;
        logic [15:0] cy;
        int unsigned spread;
        int          n_points;
        int          n_queries;
        cx = 16'($urandom);
        cy = 16'($urandom);
        case ($urandom_range(0, 3))
            0:       spread = 64;
            1:       spread = 800;
            2:       spread = 5000;
            default: spread = 65535;
        endcase
        n_points = fill_up ? $urandom_range(CAPACITY, CAPACITY + 6) : $urandom_range(1, 10);
        n_queries = fill_up ? 6 : $urandom_range(1, 4);
        send_request(brfs_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat (n_points)
            send_request(brfs_pkg::REQ_INSERT, near_coord(cx, spread), near_coord(cy, spread),
                         16'($urandom));
        // Once, stall the result side while a row of queries piles up at the input.
        if (fill_up && !hold_done)
        begin
            hold_done = 1'b1;
            long_hold_pending = 1'b1;
        end
        repeat (n_queries)
            send_request(brfs_pkg::REQ_QUERY, near_coord(cx, spread), near_coord(cy, spread),
                         16'($urandom));
    endtask

    initial
    begin : stimulus
        int phase;
        int seq_count;
        phase = 0;
        seq_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset radius: empty table, corners, unused code, radius edge.
        send_request(brfs_pkg::REQ_QUERY, 16'h1234, 16'h5678, 16'h0000);
        send_request(brfs_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(brfs_pkg::REQ_INSERT, 16'h0000, 16'h0000, 16'h0000);
        send_request(brfs_pkg::REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(brfs_pkg::REQ_INSERT, 16'h8000, 16'h7FFF, 16'hA5A5);
        send_request(brfs_pkg::REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        send_request(brfs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_request(brfs_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_request(brfs_pkg::REQ_QUERY, 16'h8000 + 16'd655, 16'h7FFF, 16'h0000);
        send_request(brfs_pkg::REQ_QUERY, 16'h8000 + 16'd656, 16'h7FFF, 16'h0000);

        // A zero radius matches nothing, not even the point itself.
        wait_for_results();
        load_radius('0);
        send_request(brfs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);

        // A radius of one matches only at distance zero.
        wait_for_results();
        load_radius(brfs_pkg::RADIUS_BITS'(1));
        send_request(brfs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_request(brfs_pkg::REQ_QUERY, 16'h0001, 16'h0000, 16'h0000);

        // The largest radius reaches corner to corner.
        wait_for_results();
        load_radius(RADIUS_MAX);
        send_request(brfs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
        send_request(brfs_pkg::REQ_QUERY, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(brfs_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        send_request(brfs_pkg::REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);

        // Random phases, each at its own radius.
        while (clear_count + insert_count + query_count < TARGET_ITEMS)
        begin
            wait_for_results();
            load_radius(pick_radius(phase));
            phase++;
            repeat ($urandom_range(3, 6))
            begin
                if (clear_count + insert_count + query_count < TARGET_ITEMS)
                begin
                    in_idle_on = ($urandom_range(0, 2) != 0);
                    out_idle_on = ($urandom_range(0, 2) != 0);
                    if (clear_count + insert_count + query_count >= TARGET_ITEMS - QUIET_ITEMS)
                        quiet = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        repeat ($urandom_range(1, 4))
                            send_request(brfs_pkg::req_t'($urandom_range(0, 3)), 16'($urandom),
                                         16'($urandom), 16'($urandom));
                    end
                    else
                        run_sequence(seq_count % 7 == 1);
                    seq_count++;
                end
            end
        end

        quiet = 1'b1;
        wait_for_results();
        $display("Sent %0d clears, %0d inserts, %0d queries and %0d unused codes under %0d radius loads.",
                 clear_count, insert_count, query_count, unused_count, radius_loads);
        $display("Received %0d matches, %0d no-match results and %0d dropped inserts.",
                 match_count, nomatch_count, dropped_count);
        if (failures == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/brfs_pkg.sv
hdl/brfs_cell.sv
hdl/brfs_dist.sv
hdl/brute_force_radius_search.sv
hdl/brfs_checker.sv
sim/brfs_checker.sv
sim/brute_force_radius_search_tb.sv
